### src/ptc_pkg.sv
// shared types and constants for the pressure/temperature compensation block
`timescale 1ns / 1ps
package ptc_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned DivSteps = 32;

  // register offsets (byte addresses)
  localparam logic [CfgAddrW-1:0] REG_AC1_AC2 = 5'd0;
  localparam logic [CfgAddrW-1:0] REG_AC3_AC4 = 5'd4;
  localparam logic [CfgAddrW-1:0] REG_AC5_AC6 = 5'd8;
  localparam logic [CfgAddrW-1:0] REG_B1_B2   = 5'd12;
  localparam logic [CfgAddrW-1:0] REG_MC_MD   = 5'd16;
  localparam logic [CfgAddrW-1:0] REG_OSS     = 5'd20;

  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  localparam logic [31:0] K_B6_OFS  = 32'd4000;
  localparam logic [31:0] K_P_SQ    = 32'd3038;
  localparam logic [31:0] K_P_LIN   = 32'hFFFF_E343; // -7357
  localparam logic [31:0] K_P_OFS   = 32'd3791;
  localparam logic [31:0] K_B7_SCL  = 32'd50000;
  localparam logic [31:0] K_B4_OFS  = 32'd32768;
  localparam logic [31:0] K_SIGN    = 32'h8000_0000;

  // calibration set seen by the datapath
  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
    logic [1:0]  oss;
  } ptc_cal_t;

  // divider request / response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } ptc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } ptc_div_rsp_t;

  function automatic logic [31:0] sext16(input logic [15:0] h);
    sext16 = {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = 32'($signed(x) >>> n);
  endfunction

endpackage

### src/ptc_if.sv
// valid/ready channel interface carrying one word
`timescale 1ns / 1ps
interface ptc_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/ptc_cfg.sv
// calibration register file behind the apb-style port
`timescale 1ns / 1ps
module ptc_cfg import ptc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ptc_cal_t            cal
);
  ptc_cal_t cal_r;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cal    = cal_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (wr_en) begin
      unique case (paddr)
        REG_AC1_AC2: cal_r.ac1_ac2 <= pwdata;
        REG_AC3_AC4: cal_r.ac3_ac4 <= pwdata;
        REG_AC5_AC6: cal_r.ac5_ac6 <= pwdata;
        REG_B1_B2:   cal_r.b1_b2   <= pwdata;
        REG_MC_MD:   cal_r.mc_md   <= pwdata;
        REG_OSS:     cal_r.oss     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr)
      REG_AC1_AC2: prdata = cal_r.ac1_ac2;
      REG_AC3_AC4: prdata = cal_r.ac3_ac4;
      REG_AC5_AC6: prdata = cal_r.ac5_ac6;
      REG_B1_B2:   prdata = cal_r.b1_b2;
      REG_MC_MD:   prdata = cal_r.mc_md;
      REG_OSS:     prdata = {30'd0, cal_r.oss};
      default:     prdata = '0;
    endcase
  end
endmodule

### src/ptc_div.sv
// radix-2 restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
module ptc_div import ptc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ptc_div_req_t req,
  output ptc_div_rsp_t rsp
);
  logic [31:0] quot_r, quot_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  assign trial = {rem_r, quot_r[31]} - {1'b0, dsr_r};

  // shift/subtract step
  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = 6'(DivSteps);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt  = trial[31:0];
        quot_nxt = {quot_r[30:0], 1'b1};
      end else begin
        rem_nxt  = {rem_r[30:0], quot_r[31]};
        quot_nxt = {quot_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(busy_r)) else $error("divider done without busy");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != 6'd1 |=> busy_r || req.start) else $error("divider stopped early");
endmodule

### src/ptc_core.sv
// sequencer around one shared 32x32 multiplier and the divider
`timescale 1ns / 1ps
module ptc_core import ptc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ptc_cal_t     cal,
  input  logic         start,
  input  logic         kind,
  input  logic [23:0]  raw,
  output logic         busy,
  output logic         res_valid,
  input  logic         res_ready,
  output logic         res_kind,
  output logic [31:0]  res_value,
  output logic         res_fault
);
  typedef enum logic [4:0] {
    S_IDLE, S_T0, S_T1, S_T2, S_TDIV, S_TEND,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_PDIV,
    S_P9, S_P10, S_P11, S_P12
  } state_t;

  state_t       state_r, state_nxt;
  logic         kind_r, kind_nxt;
  logic [23:0]  raw_r, raw_nxt;
  logic [31:0]  b5_r, b5_nxt;
  logic [31:0]  a_r, a_nxt;     // scratch
  logic [31:0]  b_r, b_nxt;
  logic [31:0]  c_r, c_nxt;
  logic [31:0]  d_r, d_nxt;
  logic [31:0]  prod_r, prod_nxt;
  logic         neg_r, neg_nxt;
  logic         val_r, val_nxt;
  logic [31:0]  value_r, value_nxt;
  logic         fault_r, fault_nxt;
  logic         res_kind_r, res_kind_nxt;
  logic         out_free;
  logic [31:0]  mul_a, mul_b;
  ptc_div_req_t dreq;
  ptc_div_rsp_t drsp;
  logic [31:0]  up, ofs;
  logic [4:0]   upsh;
  logic [1:0]   oss;

  assign oss  = cal.oss;
  assign upsh = 5'd8 - {3'd0, oss};
  assign up   = {8'd0, raw_r} >> upsh;
  assign prod_nxt = mul_a * mul_b;

  // output register can take a new word this cycle
  assign out_free = !val_r || res_ready;

  ptc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // sequencer: most states feed the shared multiplier and use the last product
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    raw_nxt   = raw_r;
    b5_nxt    = b5_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    neg_nxt   = neg_r;
    val_nxt   = val_r;
    value_nxt = value_r;
    fault_nxt = fault_r;
    res_kind_nxt = res_kind_r;
    mul_a = '0; mul_b = '0;
    dreq  = '0;
    ofs   = '0;
    // word leaves the output register
    if (val_r && res_ready) val_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (start) begin
        kind_nxt  = kind;
        raw_nxt   = raw;
        state_nxt = (kind == KIND_TEMP) ? S_T0 : S_P0;
      end
      // x1 = ((ut - ac6) * ac5) >> 15
      S_T0: begin
        mul_a = {16'd0, raw_r[15:0]} - {16'd0, cal.ac5_ac6[15:0]};
        mul_b = {16'd0, cal.ac5_ac6[31:16]};
        state_nxt = S_T1;
      end
      S_T1: begin
        a_nxt = asr(prod_r, 5'd15);
        state_nxt = S_T2;
      end
      S_T2: begin
        b_nxt = a_r + sext16(cal.mc_md[15:0]);
        c_nxt = sext16(cal.mc_md[31:16]) << 11;  // mc << 11
        if (b_nxt == '0) begin
          // zero divisor: fault word once the output register is free
          if (out_free) begin
            fault_nxt    = 1'b1;
            value_nxt    = '0;
            res_kind_nxt = kind_r;
            val_nxt      = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          neg_nxt = c_nxt[31] ^ b_nxt[31];
          dreq.start    = 1'b1;
          dreq.dividend = c_nxt[31] ? -c_nxt : c_nxt;
          dreq.divisor  = b_nxt[31] ? -b_nxt : b_nxt;
          state_nxt = S_TDIV;
        end
      end
      S_TDIV: if (drsp.done) begin
        b5_nxt    = a_r + (neg_r ? -drsp.quot : drsp.quot);
        state_nxt = S_TEND;
      end
      S_TEND: if (out_free) begin
        value_nxt    = asr(b5_r + 32'd8, 5'd4);
        fault_nxt    = 1'b0;
        res_kind_nxt = kind_r;
        val_nxt      = 1'b1;
        state_nxt    = S_IDLE;
      end
      // b6 and b6*b6
      S_P0: begin
        a_nxt = b5_r - K_B6_OFS;
        mul_a = b5_r - K_B6_OFS;
        mul_b = b5_r - K_B6_OFS;
        state_nxt = S_P1;
      end
      // sq; ac2*b6
      S_P1: begin
        b_nxt = asr(prod_r, 5'd12);
        mul_a = sext16(cal.ac1_ac2[15:0]);
        mul_b = a_r;
        state_nxt = S_P2;
      end
      // b2*sq
      S_P2: begin
        c_nxt = asr(prod_r, 5'd11);
        mul_a = sext16(cal.b1_b2[15:0]);
        mul_b = b_r;
        state_nxt = S_P3;
      end
      // b3; ac3*b6
      S_P3: begin
        d_nxt = (sext16(cal.ac1_ac2[31:16]) << 2) + asr(prod_r, 5'd11) + c_r;
        d_nxt = asr((d_nxt << oss) + 32'd2, 5'd2);
        mul_a = sext16(cal.ac3_ac4[31:16]);
        mul_b = a_r;
        state_nxt = S_P4;
      end
      // b1*sq
      S_P4: begin
        c_nxt = asr(prod_r, 5'd13);
        mul_a = sext16(cal.b1_b2[31:16]);
        mul_b = b_r;
        state_nxt = S_P5;
      end
      // x3; ac4*(x3+32768)
      S_P5: begin
        c_nxt = asr(c_r + asr(prod_r, 5'd16) + 32'd2, 5'd2);
        mul_a = {16'd0, cal.ac3_ac4[15:0]};
        mul_b = c_nxt + K_B4_OFS;
        state_nxt = S_P6;
      end
      // b4; b7 product
      S_P6: begin
        c_nxt = prod_r >> 15;
        mul_a = up - d_r;
        mul_b = K_B7_SCL >> oss;
        state_nxt = S_P7;
      end
      S_P7: begin
        b_nxt = prod_r;  // b7
        if (c_r == '0) begin
          if (out_free) begin
            fault_nxt    = 1'b1;
            value_nxt    = '0;
            res_kind_nxt = kind_r;
            val_nxt      = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          state_nxt = S_P8;
        end
      end
      S_P8: begin
        dreq.start    = 1'b1;
        dreq.dividend = (b_r < K_SIGN) ? (b_r << 1) : b_r;
        dreq.divisor  = c_r;
        state_nxt = S_PDIV;
      end
      // p
      S_PDIV: if (drsp.done) begin
        a_nxt = (b_r < K_SIGN) ? drsp.quot : (drsp.quot << 1);
        state_nxt = S_P9;
      end
      S_P9: begin
        mul_a = asr(a_r, 5'd8);
        mul_b = asr(a_r, 5'd8);
        state_nxt = S_P10;
      end
      S_P10: begin
        mul_a = prod_r;
        mul_b = K_P_SQ;
        state_nxt = S_P11;
      end
      S_P11: begin
        c_nxt = asr(prod_r, 5'd16);
        mul_a = K_P_LIN;
        mul_b = a_r;
        state_nxt = S_P12;
      end
      // final sum; keep the linear product while the output register is full
      S_P12: begin
        mul_a = K_P_LIN;
        mul_b = a_r;
        if (out_free) begin
          ofs = c_r + asr(prod_r, 5'd16) + K_P_OFS;
          value_nxt    = a_r + asr(ofs, 5'd4);
          fault_nxt    = 1'b0;
          res_kind_nxt = kind_r;
          val_nxt      = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      b5_r    <= '0;
      val_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      b5_r    <= b5_nxt;
      val_r   <= val_nxt;
    end
    kind_r  <= kind_nxt;
    raw_r   <= raw_nxt;
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
    prod_r  <= prod_nxt;
    neg_r   <= neg_nxt;
    value_r <= value_nxt;
    fault_r <= fault_nxt;
    res_kind_r <= res_kind_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign res_valid = val_r;
  assign res_kind  = res_kind_r;
  assign res_value = value_r;
  assign res_fault = fault_r;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    val_r && !res_ready |=> val_r && $stable(value_r) && $stable(fault_r)
    && $stable(res_kind_r)) else $error("result changed while stalled");
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    val_r && fault_r |-> value_r == '0) else $error("fault with nonzero value");
  a_b5_temp_only: assert property (@(posedge clk) disable iff (!rst_n)
    b5_r != $past(b5_r) |-> $past(state_r) == S_TDIV) else $error("b5 changed");
endmodule

### src/pressure_temperature_compensation.sv
// top level of the barometric pressure/temperature compensation block
`timescale 1ns / 1ps
// Usage:
//  in channel carries one word {kind, raw_value}; kind 0 is a raw temperature
//  (low 16 bits used), kind 1 a raw 24-bit pressure reading.
//  out channel returns one word {result_kind, value, fault} per input word.
//  calibration coefficients and oversampling are written through the
//  apb-style cfg port; the user must write them only while the block is
//  idle, as the block itself does not enforce it. A temperature word
//  spends most of its time in the 32-step bit-serial divider; a pressure
//  word first uses the one shared multiplier, then the same divider. A
//  zero divisor ends early, before the divider is started.
//  One word is in work at a time: in_ready is low after accept and high
//  again once the result is loaded into the output register, so a new word
//  is not taken before the result of the last one is loaded.
//  If the receiver stalls, the result is held in the output register until
//  out_ready is high; the next word may be worked on meanwhile and its
//  result waits in the core until the register is free.
//  Synchronous reset clears the calibration registers and the stored B5 term
//  and leaves the block idle with no result pending.
module pressure_temperature_compensation import ptc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  ptc_if.sink                 in_ch,
  ptc_if.source               out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  ptc_cal_t cal;
  logic     busy;
  logic     rk, rf;
  logic [31:0] rv;

  ptc_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .cal(cal)
  );

  assign in_ch.ready = !busy;

  ptc_core u_core (
    .clk(clk), .rst_n(rst_n), .cal(cal),
    .start(in_ch.valid && !busy),
    .kind(in_ch.data[24]), .raw(in_ch.data[23:0]),
    .busy(busy), .res_valid(out_ch.valid), .res_ready(out_ch.ready),
    .res_kind(rk), .res_value(rv), .res_fault(rf)
  );

  assign out_ch.data = {rk, rv, rf};
endmodule

### tb/testbench.sv
// self-checking testbench for the pressure/temperature compensation block
`timescale 1ns / 1ps
module testbench import ptc_pkg::*;;

  typedef struct {
    bit        kind;
    bit [31:0] value;
    bit        fault;
  } comp_result_t;

  // one directed row: optional calibration preset, then one word
  typedef struct {
    int        preset;
    bit        kind;
    bit [23:0] raw;
    bit        typed;
    bit [31:0] value;
    bit        fault;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  ptc_if #(.W(25)) in_ch ();
  ptc_if #(.W(34)) out_ch ();

  pressure_temperature_compensation i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // clock with period 2 ns
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // calibration mirror and stored b5 term
  bit [31:0] cal_word [6];
  bit [31:0] b5_term;
  comp_result_t pending_q [$];
  int errors = 0;
  int idle_cycles = 0;

  localparam logic [CfgAddrW-1:0] RegAddr [6] = '{REG_AC1_AC2, REG_AC3_AC4, REG_AC5_AC6,
                                                   REG_B1_B2, REG_MC_MD, REG_OSS};
  localparam int WatchdogLimit = 2000;

  // typical calibration set
  localparam bit [31:0] TypAc1Ac2 = {16'd408, 16'hFFB8};
  localparam bit [31:0] TypAc3Ac4 = {16'hC7D1, 16'd32741};
  localparam bit [31:0] TypAc5Ac6 = {16'd32757, 16'd23153};
  localparam bit [31:0] TypB1B2   = {16'd6190, 16'd4};
  localparam bit [31:0] TypMcMd   = {16'hDDF9, 16'd2868};

  function automatic bit [31:0] shr_s(bit [31:0] x, int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic bit [31:0] ext16(bit [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  // signed division truncating toward zero, on 32-bit words
  function automatic bit [31:0] div_trunc(bit [31:0] a, bit [31:0] b);
    bit [31:0] ua, ub, q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // compensated temperature or pressure for one accepted word
  function automatic comp_result_t compensate(bit kind, bit [23:0] raw);
    comp_result_t r;
    bit [31:0] ut, x1, x2, x3, den, b5, up, b6, sq, b3, b4, b7, p;
    bit [31:0] ac1, ac2, ac3, ac4, b1, b2;
    bit [1:0] oss;
    r.kind = kind;
    r.value = '0;
    r.fault = 1'b0;
    if (kind == KIND_TEMP) begin
      ut = {16'd0, raw[15:0]};
      x1 = shr_s((ut - {16'd0, cal_word[2][15:0]}) * {16'd0, cal_word[2][31:16]}, 15);
      den = x1 + ext16(cal_word[4][15:0]);
      if (den == 0) begin
        r.fault = 1'b1;
      end else begin
        x2 = div_trunc(ext16(cal_word[4][31:16]) << 11, den);
        b5 = x1 + x2;
        b5_term = b5;
        r.value = shr_s(b5 + 32'd8, 4);
      end
    end else begin
      oss = cal_word[5][1:0];
      up = {8'd0, raw} >> (8 - oss);
      ac1 = ext16(cal_word[0][31:16]);
      ac2 = ext16(cal_word[0][15:0]);
      ac3 = ext16(cal_word[1][31:16]);
      ac4 = {16'd0, cal_word[1][15:0]};
      b1 = ext16(cal_word[3][31:16]);
      b2 = ext16(cal_word[3][15:0]);
      b6 = b5_term - 32'd4000;
      sq = shr_s(b6 * b6, 12);
      x1 = shr_s(b2 * sq, 11);
      x2 = shr_s(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = shr_s(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
      x1 = shr_s(ac3 * b6, 13);
      x2 = shr_s(b1 * sq, 16);
      x3 = shr_s(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) begin
        r.fault = 1'b1;
      end else begin
        b7 = (up - b3) * (32'd50000 >> oss);
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = shr_s(p, 8);
        x1 = x1 * x1;
        x1 = shr_s(x1 * 32'd3038, 16);
        x2 = shr_s(32'hFFFF_E343 * p, 16);
        r.value = p + shr_s(x1 + x2 + 32'd3791, 4);
      end
    end
    return r;
  endfunction

  task automatic report(string what, bit [31:0] got, bit [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // apb write: setup then access phase
  task automatic cfg_write(int idx, bit [31:0] data);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= RegAddr[idx];
    cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cal_word[idx] = (idx == 5) ? (data & 32'd3) : data;
  endtask

  // stop sending, wait for the block to drain, then load a full calibration set
  task automatic load_cal(bit [31:0] w0, bit [31:0] w1, bit [31:0] w2,
                          bit [31:0] w3, bit [31:0] w4, bit [1:0] oss);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (4) @(posedge clk);
    cfg_write(0, w0);
    cfg_write(1, w1);
    cfg_write(2, w2);
    cfg_write(3, w3);
    cfg_write(4, w4);
    cfg_write(5, {30'd0, oss});
  endtask

  // sender: bursts of random length, random gaps between them
  int burst_left = 0;
  task automatic send_word(bit kind, bit [23:0] raw, bit typed, bit [31:0] value, bit fault);
    comp_result_t r;
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= {kind, raw};
    do @(posedge clk); while (!in_ch.ready);
    r = compensate(kind, raw);
    if (typed) begin
      r.value = value;
      r.fault = fault;
    end
    pending_q.push_back(r);
  endtask

  function automatic bit [31:0] jitter(bit [31:0] w);
    bit [15:0] hi, lo;
    hi = w[31:16] + 16'($urandom_range(0, 64)) - 16'd32;
    lo = w[15:0] + 16'($urandom_range(0, 64)) - 16'd32;
    return {hi, lo};
  endfunction

  // receiver stalls at a random ready rate that is redrawn periodically
  int ready_pct = 100;
  int cyc = 0;
  always @(negedge clk) begin
    cyc++;
    if (cyc % 400 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 40;
        default: ready_pct = 15;
      endcase
    end
    out_ch.ready <= rst_n && ($urandom_range(1, 100) <= ready_pct);
  end

  // result checker and watchdog
  always @(posedge clk) begin
    comp_result_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          report("unexpected word", {31'd0, out_ch.data[33]}, 32'd0);
        end else begin
          want = pending_q.pop_front();
          if (out_ch.data[33] != want.kind)
            report("result_kind", {31'd0, out_ch.data[33]}, {31'd0, want.kind});
          if (out_ch.data[32:1] != want.value)
            report("value", out_ch.data[32:1], want.value);
          if (out_ch.data[0] != want.fault)
            report("fault", {31'd0, out_ch.data[0]}, {31'd0, want.fault});
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // directed rows; typed values only where all coefficients are zero
  // or the b4 term is forced to zero
  localparam int NumRows = 20;
  stim_row_t rows [NumRows] = '{
    '{0, KIND_TEMP,  24'h000000, 1, 32'd0, 1'b1},
    '{-1, KIND_TEMP, 24'hFFFFFF, 1, 32'd0, 1'b1},
    '{-1, KIND_PRESS, 24'h000000, 1, 32'd0, 1'b1},
    '{-1, KIND_PRESS, 24'hFFFFFF, 1, 32'd0, 1'b1},
    '{1, KIND_PRESS, 24'h5D2300, 0, 32'd0, 1'b0},
    '{-1, KIND_TEMP, 24'h006CFA, 0, 32'd0, 1'b0},
    '{-1, KIND_PRESS, 24'h5D2300, 0, 32'd0, 1'b0},
    '{-1, KIND_TEMP, 24'hFF6CFA, 0, 32'd0, 1'b0},
    '{-1, KIND_TEMP, 24'h000000, 0, 32'd0, 1'b0},
    '{-1, KIND_TEMP, 24'h00FFFF, 0, 32'd0, 1'b0},
    '{-1, KIND_PRESS, 24'h000000, 0, 32'd0, 1'b0},
    '{-1, KIND_PRESS, 24'hFFFFFF, 0, 32'd0, 1'b0},
    '{2, KIND_TEMP,  24'h006CFA, 0, 32'd0, 1'b0},
    '{-1, KIND_PRESS, 24'hA5A5A5, 0, 32'd0, 1'b0},
    '{3, KIND_TEMP,  24'h001234, 0, 32'd0, 1'b0},
    '{-1, KIND_PRESS, 24'h7FFFFF, 0, 32'd0, 1'b0},
    '{4, KIND_PRESS, 24'h5D2300, 1, 32'd0, 1'b1},
    '{-1, KIND_TEMP, 24'h006CFA, 0, 32'd0, 1'b0},
    '{-1, KIND_PRESS, 24'hFFFFFF, 1, 32'd0, 1'b1},
    '{5, KIND_PRESS, 24'h800000, 0, 32'd0, 1'b0}
  };

  // main sequence
  initial begin
    bit [31:0] w [5];
    bit [1:0] oss;
    bit kind;
    bit [23:0] raw;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    foreach (cal_word[i]) cal_word[i] = '0;
    b5_term = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (rows[i]) begin
      case (rows[i].preset)
        0: load_cal(0, 0, 0, 0, 0, 2'd0);
        1: load_cal(TypAc1Ac2, TypAc3Ac4, TypAc5Ac6, TypB1B2, TypMcMd, 2'd0);
        // temperature divisor zero: ac5 and md both zero
        2: load_cal(TypAc1Ac2, TypAc3Ac4, {16'd0, 16'd23153}, TypB1B2,
                    {16'hDDF9, 16'd0}, 2'd3);
        // divisor of minus one
        3: load_cal(TypAc1Ac2, TypAc3Ac4, {16'd0, 16'd23153}, TypB1B2,
                    {16'h8000, 16'hFFFF}, 2'd1);
        // ac4 zero forces a pressure fault
        4: load_cal(TypAc1Ac2, {16'hC7D1, 16'd0}, TypAc5Ac6, TypB1B2, TypMcMd, 2'd2);
        5: load_cal(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 2'd3);
        default: ;
      endcase
      send_word(rows[i].kind, rows[i].raw, rows[i].typed, rows[i].value, rows[i].fault);
    end

    // random phases over several calibration sets
    for (int ph = 0; ph < 13; ph++) begin
      for (int k = 0; k < 5; k++) begin
        case (ph % 5)
          0: w[k] = $urandom;
          1: w[k] = (ph < 5) ? 32'h8000_8000 : 32'h7FFF_7FFF;
          default: w[k] = jitter(k == 0 ? TypAc1Ac2 : k == 1 ? TypAc3Ac4 :
                                 k == 2 ? TypAc5Ac6 : k == 3 ? TypB1B2 : TypMcMd);
        endcase
      end
      oss = 2'(ph % 4);
      load_cal(w[0], w[1], w[2], w[3], w[4], oss);
      for (int n = 0; n < 150; n++) begin
        kind = ($urandom_range(0, 9) < 4) ? KIND_TEMP : KIND_PRESS;
        if ($urandom_range(0, 1)) raw = 24'($urandom);
        else if (kind == KIND_TEMP) raw = 24'($urandom_range(20000, 35000));
        else raw = 24'($urandom_range(24'h400000, 24'hB00000));
        send_word(kind, raw, 1'b0, 32'd0, 1'b0);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
